// ----- rtl/core/gts_pkg.sv -----
// ----------------------------------------------------------------------------
// gts_pkg
// Shared types, field widths and codes for the guarded transition selector.
// ----------------------------------------------------------------------------
package gts_pkg;

  localparam int TR_ENTRIES    = 16;
  localparam int TR_W          = $clog2(TR_ENTRIES);
  localparam int COND_PER      = 4;
  localparam int PARAM_ENTRIES = 16;

  localparam int CSLOT_W = 2;
  localparam int STATE_W = 4;
  localparam int TIME_W  = 17;
  localparam int RANK_W  = 16;
  localparam int CNT_W   = 3;
  localparam int PSLOT_W = 4;
  localparam int KIND_W  = 3;
  localparam int LEVEL_W = 32;

  localparam logic [1:0] OP_HDR   = 2'd0;
  localparam logic [1:0] OP_COND  = 2'd1;
  localparam logic [1:0] OP_PARAM = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam logic [KIND_W-1:0] CMP_EQ = 3'd0;
  localparam logic [KIND_W-1:0] CMP_NE = 3'd1;
  localparam logic [KIND_W-1:0] CMP_LT = 3'd2;
  localparam logic [KIND_W-1:0] CMP_LE = 3'd3;
  localparam logic [KIND_W-1:0] CMP_GT = 3'd4;
  localparam logic [KIND_W-1:0] CMP_GE = 3'd5;

  typedef struct packed {
    logic [1:0]                operation;
    logic [3:0]                transition_slot;
    logic [CSLOT_W-1:0]        condition_slot;
    logic [STATE_W-1:0]        state_code;
    logic                      uses_exit_time;
    logic [TIME_W-1:0]         time_value;
    logic signed [RANK_W-1:0]  rank;
    logic [CNT_W-1:0]          condition_count;
    logic [PSLOT_W-1:0]        parameter_slot;
    logic [KIND_W-1:0]         compare_kind;
    logic                      is_flag;
    logic signed [LEVEL_W-1:0] operand_value;
  } in_word_t;

  typedef struct packed {
    logic       found;
    logic [3:0] transition_number;
  } out_word_t;

  typedef struct packed {
    logic [PSLOT_W-1:0]        param;
    logic [KIND_W-1:0]         kind;
    logic                      is_flag;
    logic signed [LEVEL_W-1:0] operand;
  } cond_t;

  typedef struct packed {
    logic                     valid;
    logic [STATE_W-1:0]       source;
    logic                     uses_exit;
    logic [TIME_W-1:0]        exit_point;
    logic signed [RANK_W-1:0] rank;
    logic [CNT_W-1:0]         count;
    cond_t [COND_PER-1:0]     conds;
  } trans_t;

  typedef struct packed {
    logic                     hdr_we;
    logic                     cond_we;
    logic [TR_W-1:0]          slot;
    logic [CSLOT_W-1:0]       cslot;
    logic [STATE_W-1:0]       source;
    logic                     uses_exit;
    logic [TIME_W-1:0]        exit_point;
    logic signed [RANK_W-1:0] rank;
    logic [CNT_W-1:0]         count;
    cond_t                    cond;
  } tbl_wr_t;

  typedef struct packed {
    logic                      is_flag;
    logic signed [LEVEL_W-1:0] level;
  } param_t;

  localparam int PARAM_W = $bits(param_t);

endpackage

// ----- rtl/core/gts_if.sv -----
// ----------------------------------------------------------------------------
// gts_if
// Valid/ready channels for query and write words in, selection words out.
// ----------------------------------------------------------------------------
interface gts_in_if;
  logic               valid;
  logic               ready;
  gts_pkg::in_word_t  word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface gts_out_if;
  logic               valid;
  logic               ready;
  gts_pkg::out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// ----- rtl/core/guarded_transition_selector.sv -----
// ----------------------------------------------------------------------------
// guarded_transition_selector
// Write words are accepted whenever the selector is idle. A query is taken
// only when idle, and no word is accepted until its result word is loaded.
// The scan is paced by the transition ring: one entry reaches the evaluator
// per cycle, with one parameter RAM copy per condition lane.
// Synchronous active-low reset clears transition and parameter valid bits.
// ----------------------------------------------------------------------------
module guarded_transition_selector (
  input logic       clk,
  input logic       rst_n,
  gts_in_if.sink    in_chan,
  gts_out_if.source out_chan
);
  import gts_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [TR_W:0] SCAN_END = (TR_W + 1)'(TR_ENTRIES);

  logic [1:0]               state_r;
  logic [TR_W:0]            cnt_r;
  logic [STATE_W-1:0]       q_state_r;
  logic [TIME_W-1:0]        q_time_r;
  logic                     out_vld_r;
  out_word_t                out_r;
  logic [PARAM_ENTRIES-1:0] present_r;

  in_word_t w;
  logic     in_acc;
  logic     start;
  logic     param_we;
  logic     shift_en;
  logic     out_load;
  tbl_wr_t  wr;
  trans_t   ring [TR_ENTRIES];
  param_t   param_rd [COND_PER];
  param_t   param_wdata;
  logic     best_found;
  logic [TR_W-1:0] best_idx;

  assign w        = in_chan.word;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc   = in_chan.valid && (state_r == ST_IDLE);
  assign start    = in_acc && (w.operation == OP_QUERY);
  assign param_we = in_acc && (w.operation == OP_PARAM);
  assign shift_en = (state_r == ST_SCAN) && (cnt_r < SCAN_END);
  assign out_load = (state_r == ST_DONE) && (!out_vld_r || out_chan.ready);

  always_comb begin
    wr.hdr_we       = in_acc && (w.operation == OP_HDR);
    wr.cond_we      = in_acc && (w.operation == OP_COND);
    wr.slot         = TR_W'(w.transition_slot);
    wr.cslot        = w.condition_slot;
    wr.source       = w.state_code;
    wr.uses_exit    = w.uses_exit_time;
    wr.exit_point   = w.time_value;
    wr.rank         = w.rank;
    // saturate the stored count to the lanes available
    wr.count        = (w.condition_count > CNT_W'(COND_PER)) ?
                      CNT_W'(COND_PER) : w.condition_count;
    wr.cond.param   = w.parameter_slot;
    wr.cond.kind    = w.compare_kind;
    wr.cond.is_flag = w.is_flag;
    wr.cond.operand = w.operand_value;
    param_wdata.is_flag = w.is_flag;
    param_wdata.level   = w.operand_value;
  end

  // ring: each cell takes its upper neighbor, cell 0 is the head
  for (genvar i = 0; i < TR_ENTRIES; i++) begin : g_cell
    gts_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (TR_W'(i)),
      .shift_en  (shift_en),
      .wr        (wr),
      .nbr_entry (ring[(i + 1) % TR_ENTRIES]),
      .entry     (ring[i])
    );
  end

  // one parameter RAM copy per condition lane
  for (genvar k = 0; k < COND_PER; k++) begin : g_par
    logic [PARAM_W-1:0] rdata;
    gts_ram #(
      .WIDTH (PARAM_W),
      .DEPTH (PARAM_ENTRIES)
    ) u_par (
      .clk   (clk),
      .we    (param_we),
      .waddr (w.parameter_slot),
      .wdata (param_wdata),
      .raddr (ring[0].conds[k].param),
      .rdata (rdata)
    );
    assign param_rd[k] = rdata;
  end

  gts_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .capture    (shift_en),
    .head       (ring[0]),
    .head_idx   (cnt_r[TR_W-1:0]),
    .param_rd   (param_rd),
    .present    (present_r),
    .q_state    (q_state_r),
    .q_time     (q_time_r),
    .best_found (best_found),
    .best_idx   (best_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
      present_r <= '0;
    end else begin
      if (param_we) begin
        present_r[w.parameter_slot] <= 1'b1;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_SCAN;
            cnt_r   <= '0;
          end
        end
        ST_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          // last staged entry is evaluated in the cycle cnt_r hits the end
          if (cnt_r == SCAN_END) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_state_r <= w.state_code;
      q_time_r  <= w.time_value;
    end
    if (out_load) begin
      out_r.found             <= best_found;
      out_r.transition_number <= 4'(best_idx);
    end
  end

  assign out_chan.valid = out_vld_r;
  assign out_chan.word  = out_r;

endmodule

// ----- rtl/core/gts_ram.sv -----
// ----------------------------------------------------------------------------
// gts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/gts_cell.sv -----
// ----------------------------------------------------------------------------
// gts_cell
// One transition entry of the ring: header plus its conditions. Takes the
// neighbor's entry while the ring rotates, else accepts table writes.
// ----------------------------------------------------------------------------
module gts_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [gts_pkg::TR_W-1:0]  cell_idx,
  input  logic                      shift_en,
  input  gts_pkg::tbl_wr_t          wr,
  input  gts_pkg::trans_t           nbr_entry,
  output gts_pkg::trans_t           entry
);
  import gts_pkg::*;

  trans_t entry_r;
  logic   hit;

  assign hit   = (wr.slot == cell_idx);
  assign entry = entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else if (shift_en) begin
      entry_r <= nbr_entry;
    end else begin
      if (wr.hdr_we && hit) begin
        entry_r.valid      <= 1'b1;
        entry_r.source     <= wr.source;
        entry_r.uses_exit  <= wr.uses_exit;
        entry_r.exit_point <= wr.exit_point;
        entry_r.rank       <= wr.rank;
        entry_r.count      <= wr.count;
      end
      if (wr.cond_we && hit) begin
        entry_r.conds[wr.cslot] <= wr.cond;
      end
    end
  end

endmodule

// ----- rtl/core/gts_eval.sv -----
// ----------------------------------------------------------------------------
// gts_eval
// Stages the ring head, checks state, exit point and conditions against the
// parameter words read for it, and keeps the running best transition.
// ----------------------------------------------------------------------------
module gts_eval (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               capture,
  input  gts_pkg::trans_t                    head,
  input  logic [gts_pkg::TR_W-1:0]           head_idx,
  input  gts_pkg::param_t                    param_rd [gts_pkg::COND_PER],
  input  logic [gts_pkg::PARAM_ENTRIES-1:0]  present,
  input  logic [gts_pkg::STATE_W-1:0]        q_state,
  input  logic [gts_pkg::TIME_W-1:0]         q_time,
  output logic                               best_found,
  output logic [gts_pkg::TR_W-1:0]           best_idx
);
  import gts_pkg::*;

  function automatic logic cond_holds(cond_t c, param_t p, logic pres);
    logic r;
    r = 1'b0;
    if (pres && (p.is_flag == c.is_flag)) begin
      if (c.is_flag) begin
        // flags only support equality tests on bit 0
        unique case (c.kind)
          CMP_EQ:  r = (p.level[0] == c.operand[0]);
          CMP_NE:  r = (p.level[0] != c.operand[0]);
          default: r = 1'b0;
        endcase
      end else begin
        unique case (c.kind)
          CMP_EQ:  r = (p.level == c.operand);
          CMP_NE:  r = (p.level != c.operand);
          CMP_LT:  r = (p.level <  c.operand);
          CMP_LE:  r = (p.level <= c.operand);
          CMP_GT:  r = (p.level >  c.operand);
          CMP_GE:  r = (p.level >= c.operand);
          default: r = 1'b0;
        endcase
      end
    end
    return r;
  endfunction

  trans_t                   stage_r;
  logic [TR_W-1:0]          stage_idx_r;
  logic                     stage_vld_r;
  logic                     best_found_r;
  logic [TR_W-1:0]          best_idx_r;
  logic signed [RANK_W-1:0] best_rank_r;

  logic [COND_PER-1:0] cond_ok;
  logic                qualify;
  logic                take;

  always_comb begin
    for (int k = 0; k < COND_PER; k++) begin
      cond_ok[k] = (CNT_W'(k) >= stage_r.count) ||
                   cond_holds(stage_r.conds[k], param_rd[k],
                              present[stage_r.conds[k].param]);
    end
    qualify = stage_r.valid && (stage_r.source == q_state) &&
              !(stage_r.uses_exit && (q_time < stage_r.exit_point)) &&
              (&cond_ok);
    take    = stage_vld_r && qualify &&
              (!best_found_r || (stage_r.rank > best_rank_r));
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      stage_r     <= head;
      stage_idx_r <= head_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r  <= 1'b0;
      best_found_r <= 1'b0;
      best_idx_r   <= '0;
    end else begin
      stage_vld_r <= capture;
      if (start) begin
        best_found_r <= 1'b0;
        best_idx_r   <= '0;
      end else if (take) begin
        best_found_r <= 1'b1;
        best_idx_r   <= stage_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_rank_r <= stage_r.rank;
    end
  end

  assign best_found = best_found_r;
  assign best_idx   = best_idx_r;

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for guarded_transition_selector. A short table of
// directed words runs first, then random header, condition, parameter and
// query words. Each selection word is checked against the directed table's
// value or a model of the transition and parameter tables. The source sends
// in bursts with gaps; the sink is ready, random or on a stall pattern.
// ----------------------------------------------------------------------------
module tb_top;
  import gts_pkg::*;

  localparam int RANDOM_WORDS = 1950;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;

  // compare codes with no defined meaning: always fail
  localparam logic [KIND_W-1:0] CMP_RSVD6 = 3'd6;
  localparam logic [KIND_W-1:0] CMP_RSVD7 = 3'd7;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t sel;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  gts_in_if  in_chan ();
  gts_out_if out_chan ();

  guarded_transition_selector uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  trans_t    trans_tbl [TR_ENTRIES];
  param_t    param_tbl [PARAM_ENTRIES];
  bit        param_set [PARAM_ENTRIES];
  bit        cond_seen [TR_ENTRIES*COND_PER];
  out_word_t pending_selections [$];
  stim_row_t directed_rows [$];
  int        mismatches;
  int        idle_cycles;
  int        burst_left;
  int        sink_phase;
  int        sink_mode;
  logic [7:0] sink_pattern;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // -------------------------------------------------------------- model
  function automatic bit condition_passes(cond_t c);
    logic signed [LEVEL_W-1:0] have;
    logic signed [LEVEL_W-1:0] want;
    if (!param_set[c.param]) return 1'b0;
    if (param_tbl[c.param].is_flag != c.is_flag) return 1'b0;
    have = param_tbl[c.param].level;
    want = c.operand;
    if (c.is_flag) begin
      // flags compare bit 0 only and have no ordering
      case (c.kind)
        CMP_EQ:  return have[0] == want[0];
        CMP_NE:  return have[0] != want[0];
        default: return 1'b0;
      endcase
    end
    case (c.kind)
      CMP_EQ:  return have == want;
      CMP_NE:  return have != want;
      CMP_LT:  return have < want;
      CMP_LE:  return have <= want;
      CMP_GT:  return have > want;
      CMP_GE:  return have >= want;
      default: return 1'b0;
    endcase
  endfunction

  function automatic out_word_t select_transition(in_word_t q);
    out_word_t r;
    logic signed [RANK_W-1:0] best_rank;
    logic signed [RANK_W-1:0] cand;
    bit ok;
    r = '0;
    best_rank = '0;
    for (int t = 0; t < TR_ENTRIES; t++) begin
      if (!trans_tbl[t].valid || trans_tbl[t].source != q.state_code) continue;
      if (trans_tbl[t].uses_exit && q.time_value < trans_tbl[t].exit_point) continue;
      ok = 1'b1;
      for (int k = 0; k < int'(trans_tbl[t].count); k++)
        if (!condition_passes(trans_tbl[t].conds[k])) ok = 1'b0;
      if (!ok) continue;
      cand = trans_tbl[t].rank;
      // strict compare: on equal rank keep the earlier entry
      if (!r.found || cand > best_rank) begin
        r.found = 1'b1;
        r.transition_number = 4'(t);
        best_rank = cand;
      end
    end
    return r;
  endfunction

  function automatic void apply_word(stim_row_t row);
    in_word_t w;
    out_word_t sel;
    int c;
    w = row.word;
    c = int'(w.transition_slot) * COND_PER + int'(w.condition_slot);
    case (w.operation)
      OP_HDR: begin
        trans_tbl[w.transition_slot].valid      = 1'b1;
        trans_tbl[w.transition_slot].source     = w.state_code;
        trans_tbl[w.transition_slot].uses_exit  = w.uses_exit_time;
        trans_tbl[w.transition_slot].exit_point = w.time_value;
        trans_tbl[w.transition_slot].rank       = w.rank;
        trans_tbl[w.transition_slot].count      =
          (int'(w.condition_count) > COND_PER) ? CNT_W'(COND_PER) : w.condition_count;
      end
      OP_COND: begin
        trans_tbl[w.transition_slot].conds[w.condition_slot].param   = w.parameter_slot;
        trans_tbl[w.transition_slot].conds[w.condition_slot].kind    = w.compare_kind;
        trans_tbl[w.transition_slot].conds[w.condition_slot].is_flag = w.is_flag;
        trans_tbl[w.transition_slot].conds[w.condition_slot].operand = w.operand_value;
        cond_seen[c] = 1'b1;
      end
      OP_PARAM: begin
        param_set[w.parameter_slot]         = 1'b1;
        param_tbl[w.parameter_slot].is_flag = w.is_flag;
        param_tbl[w.parameter_slot].level   = w.operand_value;
      end
      default: begin
        sel = row.typed ? row.sel : select_transition(w);
        pending_selections = {pending_selections, sel};
      end
    endcase
  endfunction

  function automatic void add_row(stim_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  // ------------------------------------------------------- word builders
  function automatic in_word_t noise_word();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_word_t)-1:0];
  endfunction

  function automatic in_word_t hdr_word(logic [3:0] slot, logic [STATE_W-1:0] state,
                                        bit uses_exit, logic [TIME_W-1:0] exit_point,
                                        logic signed [RANK_W-1:0] rank,
                                        logic [CNT_W-1:0] count);
    in_word_t w;
    w = noise_word();
    w.operation       = OP_HDR;
    w.transition_slot = slot;
    w.state_code      = state;
    w.uses_exit_time  = uses_exit;
    w.time_value      = exit_point;
    w.rank            = rank;
    w.condition_count = count;
    return w;
  endfunction

  function automatic in_word_t cond_word(logic [3:0] slot, logic [CSLOT_W-1:0] cslot,
                                         logic [PSLOT_W-1:0] pslot, logic [KIND_W-1:0] kind,
                                         bit flag, logic signed [LEVEL_W-1:0] operand);
    in_word_t w;
    w = noise_word();
    w.operation       = OP_COND;
    w.transition_slot = slot;
    w.condition_slot  = cslot;
    w.parameter_slot  = pslot;
    w.compare_kind    = kind;
    w.is_flag         = flag;
    w.operand_value   = operand;
    return w;
  endfunction

  function automatic in_word_t param_word(logic [PSLOT_W-1:0] pslot, bit flag,
                                          logic signed [LEVEL_W-1:0] level);
    in_word_t w;
    w = noise_word();
    w.operation      = OP_PARAM;
    w.parameter_slot = pslot;
    w.is_flag        = flag;
    w.operand_value  = level;
    return w;
  endfunction

  function automatic in_word_t query_word(logic [STATE_W-1:0] state, logic [TIME_W-1:0] at);
    in_word_t w;
    w = noise_word();
    w.operation  = OP_QUERY;
    w.state_code = state;
    w.time_value = at;
    return w;
  endfunction

  function automatic stim_row_t as_row(in_word_t w, bit typed = 1'b0, bit found = 1'b0,
                                       logic [3:0] number = 4'd0);
    stim_row_t row;
    row.word  = w;
    row.typed = typed;
    row.sel.found = found;
    row.sel.transition_number = number;
    return row;
  endfunction

  // ------------------------------------------------------ random values
  function automatic logic [STATE_W-1:0] pick_state();
    // crowd most traffic onto a few states so queries find candidates
    if ($urandom_range(0, 4) == 0) return STATE_W'($urandom_range(0, 15));
    return STATE_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    if ($urandom_range(0, 9) == 0) return TIME_W'($urandom_range(0, 131071));
    if ($urandom_range(0, 7) == 0) return TIME_W'(65536);
    return TIME_W'($urandom_range(0, 65536));
  endfunction

  function automatic logic signed [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 32'sh0000_0000;
      1:       return 32'sh0000_0001;
      2:       return -32'sh1;
      3:       return 32'sh7FFF_FFFF;
      4:       return 32'sh8000_0000;
      5:       return 32'sh0001_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_word_t rand_cond_word(logic [3:0] slot, logic [CSLOT_W-1:0] cslot);
    logic [PSLOT_W-1:0] p;
    logic [KIND_W-1:0] kind;
    logic signed [LEVEL_W-1:0] operand;
    bit flag;
    p = PSLOT_W'($urandom_range(0, 15));
    if (param_set[p] && ($urandom_range(0, 4) != 0)) flag = param_tbl[p].is_flag;
    else flag = 1'($urandom_range(0, 1));
    if (flag && ($urandom_range(0, 4) != 0)) kind = KIND_W'($urandom_range(0, 1));
    else if ($urandom_range(0, 15) == 0) kind = ($urandom_range(0, 1) != 0) ? CMP_RSVD7 : CMP_RSVD6;
    else kind = KIND_W'($urandom_range(0, 5));
    // land near the live level so equality and the boundaries get hit
    if (param_set[p] && ($urandom_range(0, 1) != 0))
      operand = param_tbl[p].level + LEVEL_W'($urandom_range(0, 2)) - 32'sd1;
    else
      operand = pick_level();
    return cond_word(slot, cslot, p, kind, flag, operand);
  endfunction

  // ---------------------------------------------------------- source side
  task automatic send_word(input stim_row_t row);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_chan.valid <= 1'b1;
    in_chan.word  <= row.word;
    do @(posedge clk); while (!in_chan.ready);
    burst_left--;
    apply_word(row);
    @(negedge clk);
  endtask

  task automatic send_header(input in_word_t h);
    int need;
    need = (int'(h.condition_count) > COND_PER) ? COND_PER : int'(h.condition_count);
    // never let a live transition point at an unwritten condition
    for (int k = 0; k < need; k++)
      if (!cond_seen[int'(h.transition_slot) * COND_PER + k])
        send_word(as_row(rand_cond_word(h.transition_slot, CSLOT_W'(k))));
    send_word(as_row(h));
  endtask

  // ------------------------------------------------------------ sink side
  always @(negedge clk) begin
    if (sink_phase == 0) begin
      sink_mode    = $urandom_range(0, 2);
      sink_pattern = 8'($urandom_range(1, 255));
      sink_phase   = $urandom_range(50, 400);
    end
    sink_phase--;
    if (!rst_n) out_chan.ready <= 1'b0;
    else begin
      case (sink_mode)
        0:       out_chan.ready <= 1'b1;
        1:       out_chan.ready <= 1'($urandom_range(0, 1));
        default: out_chan.ready <= sink_pattern[sink_phase % 8];
      endcase
    end
  end

  always @(posedge clk) begin
    out_word_t expected;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_selections.size() == 0) begin
        $display("%0t: unexpected selection word found=%0b number=%0d", $realtime,
                 out_chan.word.found, out_chan.word.transition_number);
        mismatches++;
      end else begin
        expected = pending_selections.pop_front();
        if (out_chan.word.found !== expected.found) begin
          $display("%0t: found expected %0b got %0b", $realtime, expected.found,
                   out_chan.word.found);
          mismatches++;
        end
        if (out_chan.word.transition_number !== expected.transition_number) begin
          $display("%0t: transition_number expected %0d got %0d", $realtime,
                   expected.transition_number, out_chan.word.transition_number);
          mismatches++;
        end
      end
    end
  end

  // watchdog: any accepted word on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ------------------------------------------------------------- stimulus
  initial begin
    int pick;
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.word   = '0;
    out_chan.ready = 1'b0;
    mismatches     = 0;
    idle_cycles    = 0;
    burst_left     = 0;
    sink_phase     = 0;
    foreach (trans_tbl[i]) trans_tbl[i] = '0;
    foreach (param_tbl[i]) param_tbl[i] = '0;
    foreach (param_set[i]) param_set[i] = 1'b0;
    foreach (cond_seen[i]) cond_seen[i] = 1'b0;

    // empty tables: nothing qualifies
    add_row(as_row(query_word(4'd0, 17'd0), 1'b1, 1'b0, 4'd0));
    add_row(as_row(query_word(4'd15, 17'd65536), 1'b1, 1'b0, 4'd0));
    add_row(as_row(param_word(4'd0, 1'b0, 32'sh7FFF_FFFF)));
    add_row(as_row(param_word(4'd1, 1'b1, 32'shFFFF_FFFE)));
    add_row(as_row(param_word(4'd2, 1'b0, 32'sh8000_0000)));
    add_row(as_row(cond_word(4'd0, 2'd0, 4'd0, CMP_GE, 1'b0, 32'sh7FFF_FFFF)));
    add_row(as_row(cond_word(4'd0, 2'd1, 4'd1, CMP_EQ, 1'b1, 32'sh0)));
    add_row(as_row(hdr_word(4'd0, 4'd3, 1'b1, 17'd65536, 16'sh7FFF, 3'd2)));
    // exit point one tick late, then exactly reached
    add_row(as_row(query_word(4'd3, 17'd65535), 1'b1, 1'b0, 4'd0));
    add_row(as_row(query_word(4'd3, 17'd65536), 1'b1, 1'b1, 4'd0));
    // parameter never set
    add_row(as_row(cond_word(4'd1, 2'd0, 4'd9, CMP_EQ, 1'b0, 32'sh0)));
    add_row(as_row(hdr_word(4'd1, 4'd3, 1'b0, 17'd0, 16'sh8000, 3'd1)));
    add_row(as_row(query_word(4'd3, 17'd0), 1'b1, 1'b0, 4'd0));
    // flag with ordering, type mismatch, undefined compare code
    add_row(as_row(cond_word(4'd2, 2'd0, 4'd1, CMP_LT, 1'b1, 32'sh1)));
    add_row(as_row(cond_word(4'd3, 2'd0, 4'd0, CMP_EQ, 1'b1, 32'sh7FFF_FFFF)));
    add_row(as_row(cond_word(4'd7, 2'd0, 4'd0, CMP_RSVD6, 1'b0, 32'sh0)));
    add_row(as_row(hdr_word(4'd2, 4'd3, 1'b0, 17'd0, 16'sh0, 3'd1)));
    add_row(as_row(hdr_word(4'd3, 4'd3, 1'b0, 17'd0, 16'sh0, 3'd1)));
    add_row(as_row(hdr_word(4'd7, 4'd3, 1'b0, 17'd0, 16'sh0, 3'd1)));
    add_row(as_row(query_word(4'd3, 17'd0), 1'b1, 1'b0, 4'd0));
    // count of 7 saturates to 4, all four hold; entry 6 ties on rank
    add_row(as_row(cond_word(4'd0, 2'd2, 4'd2, CMP_LE, 1'b0, 32'sh8000_0000)));
    add_row(as_row(cond_word(4'd0, 2'd3, 4'd1, CMP_NE, 1'b1, 32'sh1)));
    add_row(as_row(hdr_word(4'd0, 4'd3, 1'b0, 17'd0, 16'sh0, 3'd7)));
    add_row(as_row(hdr_word(4'd6, 4'd3, 1'b0, 17'd0, 16'sh0, 3'd0)));
    add_row(as_row(query_word(4'd3, 17'd0), 1'b1, 1'b1, 4'd0));
    add_row(as_row(query_word(4'd3, 17'd131071)));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_word(directed_rows[i]);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)
        send_word(as_row(query_word(pick_state(), pick_time())));
      else if (pick < 55)
        send_word(as_row(param_word(PSLOT_W'($urandom_range(0, 15)),
                                    1'($urandom_range(0, 3) == 0), pick_level())));
      else if (pick < 75)
        send_word(as_row(rand_cond_word(4'($urandom_range(0, 15)),
                                        CSLOT_W'($urandom_range(0, 3)))));
      else
        send_header(hdr_word(4'($urandom_range(0, 15)), pick_state(),
                             1'($urandom_range(0, 1)), pick_time(),
                             ($urandom_range(0, 3) == 0) ? RANK_W'($urandom)
                                                         : RANK_W'($urandom_range(0, 2)) - 16'sd1,
                             ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 7))
                                                         : CNT_W'($urandom_range(0, 2))));
    end
    in_chan.valid <= 1'b0;

    while (pending_selections.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
